>>> src/box_motion_collision_step_assert.svh
// assertion macros used by the checker file
`ifndef BOX_MOTION_COLLISION_STEP_ASSERT_SVH
`define BOX_MOTION_COLLISION_STEP_ASSERT_SVH

// same-cycle implication
`define BMCS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BMCS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/bmcs_pkg.sv
// package with types, constants and helpers of the box motion and collision block
package bmcs_pkg;

  localparam int IN_TDATA_W   = 208;
  localparam int OUT_FIELDS_W = 129;
  localparam int OUT_TDATA_W  = 136;
  localparam int CFG_IDX_W    = 3;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_RESOLVE = 2'd1,
    OP_SET_VEL = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VEL_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VEL_Y = 3'd5;

  localparam logic [30:0] BOX_DIM_RESET = 31'd1048576;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = S32_MIN;
    end else begin
      r = S32_MAX;
    end
    return r;
  endfunction

endpackage

>>> src/box_motion_collision_step.sv
// top level: one moving box with tick, collision resolve, set velocity and restart
// from request to result: restart and set velocity go straight to the result state, tick
// multiplies and adds x then y, resolve with a still axis snaps, resolve with both axes moving divides first
// the moving resolve runs one restoring divider twice, 32 quotient bits each, one bit a cycle
// a new request is taken the cycle after the result is registered
// reset (rst_n low, synchronous) zeroes position, velocity and flag and loads config defaults
module box_motion_collision_step import bmcs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // step_time, rect_x, rect_y, rect_w, rect_h, new_vel_x, new_vel_y, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // operation
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pos_x, pos_y, vel_x, vel_y, grounded, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]            cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_X, ST_MUL_Y, ST_ADD_Y, ST_PREP, ST_NUM, ST_LOAD,
    ST_DIV, ST_QEND, ST_CMP, ST_SNAP, ST_FIN
  } state_t;

  state_t state_r;

  logic [30:0]        box_w_r, box_h_r;
  logic signed [31:0] start_x_r, start_y_r, start_vx_r, start_vy_r;

  logic signed [31:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r;
  logic               gnd_r;

  logic [15:0]        dt_r;
  logic signed [31:0] rx_r, ry_r;
  logic [30:0]        rw_r, rh_r;

  logic signed [48:0] prod_r;
  logic signed [33:0] bx_r, by_r, ox_r, oy_r, num_r;
  logic               axis_r, pick_x_r;
  logic signed [31:0] fx_r, fy_r;

  logic [31:0]        rem_r, sh_r, quo_r, dsr_r;
  logic [4:0]         cnt_r;
  logic               neg_r, ovf_r;

  logic                    out_tvalid_r;
  logic [OUT_FIELDS_W-1:0] out_fld_r;

  // input unpack
  op_t                in_op;
  logic [15:0]        in_dt;
  logic signed [31:0] in_rx, in_ry, in_nvx, in_nvy;
  logic [30:0]        in_rw, in_rh;

  assign in_op  = op_t'(in_tuser);
  assign in_dt  = in_tdata[15:0];
  assign in_rx  = in_tdata[47:16];
  assign in_ry  = in_tdata[79:48];
  assign in_rw  = in_tdata[110:80];
  assign in_rh  = in_tdata[141:111];
  assign in_nvx = in_tdata[173:142];
  assign in_nvy = in_tdata[205:174];

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, out_fld_r};

  logic vx_zero, vy_zero, vx_pos, vy_pos;
  assign vx_zero = (vel_x_r == 32'sd0);
  assign vy_zero = (vel_y_r == 32'sd0);
  assign vx_pos  = !vel_x_r[31] && !vx_zero;
  assign vy_pos  = !vel_y_r[31] && !vy_zero;

  // shared multiplier for the tick
  logic signed [31:0] mul_a;
  logic signed [48:0] mul_p;
  logic signed [31:0] tick_pos;
  logic signed [33:0] tick_sum;
  assign mul_a    = (state_r == ST_MUL_X) ? vel_x_r : vel_y_r;
  assign mul_p    = mul_a * $signed({1'b0, dt_r});
  assign tick_pos = (state_r == ST_MUL_Y) ? pos_x_r : pos_y_r;
  assign tick_sum = 34'(tick_pos) + 34'($signed(prod_r[48:16]));

  // divider operands and step
  logic [33:0]        num_abs;
  logic signed [31:0] den_sel;
  logic [31:0]        den_abs;
  logic [33:0]        div_t;
  logic               q_over;
  logic signed [31:0] q_res;
  assign num_abs = num_r[33] ? 34'(-num_r) : 34'(num_r);
  assign den_sel = axis_r ? vel_y_r : vel_x_r;
  assign den_abs = den_sel[31] ? (~den_sel + 32'd1) : den_sel;
  assign div_t   = {1'b0, rem_r, sh_r[31]} - {2'b00, dsr_r};
  assign q_over  = ovf_r || (neg_r ? (quo_r > 32'h8000_0000) : quo_r[31]);
  assign q_res   = q_over ? (neg_r ? S32_MIN : S32_MAX)
                          : (neg_r ? $signed(~quo_r + 32'd1) : $signed(quo_r));

  // face snap sums
  logic signed [33:0] snap_x, snap_y;
  assign snap_x = 34'(rx_r) + (vx_pos ? -$signed({3'b000, box_w_r}) : $signed({3'b000, rw_r}));
  assign snap_y = 34'(ry_r) + (!vel_y_r[31] ? -$signed({3'b000, box_h_r})
                                            : $signed({3'b000, rh_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      box_w_r      <= BOX_DIM_RESET;
      box_h_r      <= BOX_DIM_RESET;
      start_x_r    <= '0;
      start_y_r    <= '0;
      start_vx_r   <= '0;
      start_vy_r   <= '0;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      vel_x_r      <= '0;
      vel_y_r      <= '0;
      gnd_r        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BOX_WIDTH:   box_w_r    <= cfg_data[30:0];
          CFG_BOX_HEIGHT:  box_h_r    <= cfg_data[30:0];
          CFG_START_X:     start_x_r  <= cfg_data;
          CFG_START_Y:     start_y_r  <= cfg_data;
          CFG_START_VEL_X: start_vx_r <= cfg_data;
          CFG_START_VEL_Y: start_vy_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_tvalid_r && out_tready && state_r != ST_FIN) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            dt_r <= in_dt;
            rx_r <= in_rx;
            ry_r <= in_ry;
            rw_r <= in_rw;
            rh_r <= in_rh;
            unique case (in_op)
              OP_TICK: state_r <= ST_MUL_X;
              OP_RESOLVE: begin
                axis_r <= 1'b0;
                if (vx_zero || vy_zero) begin
                  pick_x_r <= vy_zero && !vx_zero;
                  state_r  <= ST_SNAP;
                end else begin
                  state_r <= ST_PREP;
                end
              end
              OP_SET_VEL: begin
                vel_x_r <= in_nvx;
                vel_y_r <= in_nvy;
                state_r <= ST_FIN;
              end
              OP_RESTART: begin
                pos_x_r <= start_x_r;
                pos_y_r <= start_y_r;
                vel_x_r <= start_vx_r;
                vel_y_r <= start_vy_r;
                gnd_r   <= 1'b0;
                state_r <= ST_FIN;
              end
            endcase
          end
        end
        ST_MUL_X: begin
          prod_r  <= mul_p;
          state_r <= ST_MUL_Y;
        end
        ST_MUL_Y: begin
          pos_x_r <= sat34(tick_sum);
          prod_r  <= mul_p;
          state_r <= ST_ADD_Y;
        end
        ST_ADD_Y: begin
          pos_y_r <= sat34(tick_sum);
          gnd_r   <= 1'b0;
          state_r <= ST_FIN;
        end
        ST_PREP: begin
          // leading corners in the direction of travel
          bx_r    <= 34'(pos_x_r) + (vx_pos ? $signed({3'b000, box_w_r}) : 34'sd0);
          by_r    <= 34'(pos_y_r) + (vy_pos ? $signed({3'b000, box_h_r}) : 34'sd0);
          ox_r    <= 34'(rx_r) + (vx_pos ? 34'sd0 : $signed({3'b000, rw_r}));
          oy_r    <= 34'(ry_r) + (vy_pos ? 34'sd0 : $signed({3'b000, rh_r}));
          state_r <= ST_NUM;
        end
        ST_NUM: begin
          num_r   <= axis_r ? (by_r - oy_r) : (bx_r - ox_r);
          state_r <= ST_LOAD;
        end
        ST_LOAD: begin
          ovf_r   <= ({14'd0, num_abs[33:16]} >= den_abs);
          rem_r   <= {14'd0, num_abs[33:16]};
          sh_r    <= {num_abs[15:0], 16'd0};
          dsr_r   <= den_abs;
          neg_r   <= num_r[33] ^ den_sel[31];
          quo_r   <= '0;
          cnt_r   <= 5'd31;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (!div_t[33]) begin
            rem_r <= div_t[31:0];
          end else begin
            rem_r <= {rem_r[30:0], sh_r[31]};
          end
          quo_r <= {quo_r[30:0], !div_t[33]};
          sh_r  <= {sh_r[30:0], 1'b0};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            state_r <= ST_QEND;
          end
        end
        ST_QEND: begin
          if (!axis_r) begin
            fx_r    <= q_res;
            axis_r  <= 1'b1;
            state_r <= ST_NUM;
          end else begin
            fy_r    <= q_res;
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          pick_x_r <= (fy_r > fx_r);
          state_r  <= ST_SNAP;
        end
        ST_SNAP: begin
          if (pick_x_r) begin
            pos_x_r <= sat34(snap_x);
            vel_x_r <= '0;
          end else begin
            pos_y_r <= sat34(snap_y);
            vel_y_r <= '0;
            if (!vel_y_r[31]) begin
              gnd_r <= 1'b1;
            end
          end
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_tvalid_r || out_tready) begin
            out_fld_r    <= {gnd_r, vel_y_r, vel_x_r, pos_y_r, pos_x_r};
            out_tvalid_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/bmcs_check.sv
// port checker for the box motion and collision block, bound to the top level
`include "box_motion_collision_step_assert.svh"

module bmcs_check import bmcs_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic [1:0]             in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_IDX_W-1:0]   cfg_index,
  input logic [31:0]            cfg_data
);

  `BMCS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped or changed while stalled")
  `BMCS_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_tvalid && in_tready, !in_tready && !cfg_ready, "block not busy after request")
  `BMCS_ASSERT_IMP(a_cfg_when_idle, clk, rst_n, 1'b1, cfg_ready == in_tready, "config ready differs from request ready")
  `BMCS_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0, "result padding not zero")

endmodule

bind box_motion_collision_step bmcs_check u_bmcs_check (.*);
